[design/apa_pkg.sv]
// ============================================================================
// apa_pkg : averaged pressure alarm shared definitions
// Widths, window depth, buzzer timing constants and shared types.
// ============================================================================
package apa_pkg;

    // Window depth of both sample rows
    localparam int WINDOW      = 16;
    localparam int WINDOW_LOG2 = $clog2(WINDOW);

    localparam int SAMPLE_W    = 17;
    localparam int SUM_W       = SAMPLE_W + WINDOW_LOG2;
    localparam int TIME_W      = 32;
    localparam int INTERVAL_W  = 16;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;

    // Configuration space
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_UPDATE_INTERVAL = '0;

    // Stream widths
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 40;

    // Buzzer half period 500 ms = 4 * 125; quotient by 125 via reciprocal
    localparam int BUZZ_HALF_MS = 500;
    localparam int BUZZ_SHIFT   = 2;
    localparam int BUZZ_ODD     = BUZZ_HALF_MS >> BUZZ_SHIFT;
    localparam int Q_W          = TIME_W - BUZZ_SHIFT;
    localparam int RECIP_K      = Q_W + 7;
    localparam longint unsigned RECIP_M_FULL =
        ((64'd1 << RECIP_K) + 64'(BUZZ_ODD) - 64'd1) / 64'(BUZZ_ODD);
    localparam int M_W          = 31;
    localparam logic [M_W-1:0] RECIP_M = M_W'(RECIP_M_FULL);
    localparam int Q_LO_W       = Q_W / 2;
    localparam int Q_HI_W       = Q_W - Q_LO_W;
    localparam int PP_W         = Q_HI_W + M_W;
    localparam int PROD_W       = Q_W + M_W;

    // One chamber / outside sample pair held by a window cell
    typedef struct packed {
        logic [SAMPLE_W-1:0] outside;
        logic [SAMPLE_W-1:0] chamber;
    } sample_pair_t;

    // Indicator fields carried down the pipe
    typedef struct packed {
        logic                updated;
        logic [SAMPLE_W-1:0] outside_average;
        logic [SAMPLE_W-1:0] chamber_average;
        logic                red;
    } ind_t;

    // Buzzer control for one item
    typedef struct packed {
        logic load;
        logic clear;
    } buz_ctl_t;

endpackage

[design/apa_cell.sv]
// ============================================================================
// apa_cell : one window cell
// Holds one sample pair and hands it to the next cell on every item.
// ============================================================================
module apa_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  shift_en,
    input  apa_pkg::sample_pair_t din,
    output apa_pkg::sample_pair_t dout
);

    apa_pkg::sample_pair_t pair_reg;

    // window entries start at zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg <= '0;
        end else if (shift_en) begin
            pair_reg <= din;
        end
    end

    assign dout = pair_reg;

endmodule

[design/apa_buzz_phase.sv]
// ============================================================================
// apa_buzz_phase : buzzer phase bit
// Bit 0 of q / 125 by reciprocal multiply, split in two registered halves.
// ============================================================================
module apa_buzz_phase (
    input  logic                      aclk,
    input  logic                      load_en,
    input  logic [apa_pkg::Q_W-1:0]   q,
    output logic                      phase
);

    logic [apa_pkg::PP_W-1:0]   pp_hi_reg;
    logic [apa_pkg::PP_W-1:0]   pp_lo_reg;
    logic [apa_pkg::PP_W-1:0]   pp_hi_next;
    logic [apa_pkg::PP_W-1:0]   pp_lo_next;
    logic [apa_pkg::PROD_W-1:0] prod;

    assign pp_hi_next = apa_pkg::PP_W'(q[apa_pkg::Q_W-1:apa_pkg::Q_LO_W])
                        * apa_pkg::PP_W'(apa_pkg::RECIP_M);
    assign pp_lo_next = apa_pkg::PP_W'(q[apa_pkg::Q_LO_W-1:0])
                        * apa_pkg::PP_W'(apa_pkg::RECIP_M);

    always_ff @(posedge aclk) begin
        if (load_en) begin
            pp_hi_reg <= pp_hi_next;
            pp_lo_reg <= pp_lo_next;
        end
    end

    // recombine halves; quotient bit 0 sits at bit RECIP_K
    assign prod  = (apa_pkg::PROD_W'(pp_hi_reg) << apa_pkg::Q_LO_W)
                   + apa_pkg::PROD_W'(pp_lo_reg);
    assign phase = prod[apa_pkg::RECIP_K];

endmodule

[design/averaged_pressure_alarm.sv]
// ============================================================================
// averaged_pressure_alarm : windowed pressure comparator with latched alarm
// Row of sample cells with running sums, update timer, alarm and buzzer.
// ============================================================================
//
//  port group   dir  handshake          payload
//  s_*          in   s_tvalid/s_tready  s_tdata: samples, timestamp, buttons
//  m_*          out  m_tvalid/m_tready  m_tdata: indicators, averages, flag
//  p*           in   APB, pready = 1    update_interval_ms at byte address 0
//
//  One item per cycle sustained unless stalled. Items pass stage 1, stage 2
//  and the output register. The accept cycle carries the whole state update
//  (window shift, running sums, averages, compare, alarm), which is the
//  loop that sets the rate; the buzzer phase divide trails it over two
//  registered stages. Synchronous active-low reset clears the window cells,
//  sums and alarm state at once; the interval register returns to 1000 ms.
//  A stalled output only blocks input once all three stages hold an item.
//
module averaged_pressure_alarm (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [16:0] chamber_pressure, [33:17] outside_pressure, [65:34] now_ms,
    // [66] silence_pressed, [67] display_pressed, [71:68] zero
    input  logic [apa_pkg::S_DATA_W-1:0]   s_tdata,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] red_led, [1] green_led, [2] buzzer, [19:3] chamber_average,
    // [36:20] outside_average, [37] updated, [39:38] zero
    output logic [apa_pkg::M_DATA_W-1:0]   m_tdata,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [apa_pkg::ADDR_W-1:0]     paddr,
    input  logic [apa_pkg::DATA_W-1:0]     pwdata,
    output logic [apa_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic [apa_pkg::SAMPLE_W-1:0] s_chamber;
    logic [apa_pkg::SAMPLE_W-1:0] s_outside;
    logic [apa_pkg::TIME_W-1:0]   s_now;
    logic                         s_silence;
    logic                         s_display;

    assign s_chamber = s_tdata[16:0];
    assign s_outside = s_tdata[33:17];
    assign s_now     = s_tdata[65:34];
    assign s_silence = s_tdata[66];
    assign s_display = s_tdata[67];

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [apa_pkg::INTERVAL_W-1:0] interval_reg;
    logic                           cfg_wr;
    logic                           cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[apa_pkg::ADDR_W-1:2] == apa_pkg::REG_UPDATE_INTERVAL);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = cfg_hit ? apa_pkg::DATA_W'(interval_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= apa_pkg::INTERVAL_RESET;
        end else if (cfg_wr && cfg_hit) begin
            interval_reg <= pwdata[apa_pkg::INTERVAL_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipe control: each stage moves on when the next one is free
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, out_valid_reg;
    logic out_en, adv2, en2, adv1, en1, s_fire;

    assign out_en   = !out_valid_reg || m_tready;
    assign adv2     = v2_reg && out_en;
    assign en2      = !v2_reg || adv2;
    assign adv1     = v1_reg && en2;
    assign en1      = !v1_reg || adv1;
    assign s_tready = en1;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                v1_reg <= 1'b1;
            end else if (adv1) begin
                v1_reg <= 1'b0;
            end
            if (adv1) begin
                v2_reg <= 1'b1;
            end else if (adv2) begin
                v2_reg <= 1'b0;
            end
            if (adv2) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample window: row of cells, oldest pair falls off the far end
    // ------------------------------------------------------------------
    apa_pkg::sample_pair_t cell_in  [apa_pkg::WINDOW];
    apa_pkg::sample_pair_t cell_out [apa_pkg::WINDOW];
    apa_pkg::sample_pair_t oldest;

    assign cell_in[0] = '{outside: s_outside, chamber: s_chamber};

    genvar gi;
    generate
        for (gi = 0; gi < apa_pkg::WINDOW; gi++) begin : g_cell
            if (gi > 0) begin : g_link
                assign cell_in[gi] = cell_out[gi-1];
            end
            apa_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (s_fire),
                .din      (cell_in[gi]),
                .dout     (cell_out[gi])
            );
        end
    endgenerate

    assign oldest = cell_out[apa_pkg::WINDOW-1];

    // ------------------------------------------------------------------
    // State update in the accept cycle
    // ------------------------------------------------------------------
    logic [apa_pkg::SUM_W-1:0]    chamber_sum_reg, chamber_sum_next;
    logic [apa_pkg::SUM_W-1:0]    outside_sum_reg, outside_sum_next;
    logic [apa_pkg::TIME_W-1:0]   next_update_reg;
    logic [apa_pkg::TIME_W-1:0]   alarm_start_reg;
    logic                         armed_reg, alarm_active_reg;
    logic                         red_reg;
    logic [apa_pkg::SAMPLE_W-1:0] chamber_avg_reg, outside_avg_reg;

    logic [apa_pkg::SAMPLE_W-1:0] chamber_avg_calc, outside_avg_calc;
    logic                         red_calc;
    logic                         do_update;
    logic                         armed_sil, alarm_sil;
    logic                         armed_next, alarm_next;
    logic [apa_pkg::TIME_W-1:0]   elapsed;

    // running sums stay exact: drop the oldest pair, add the new one
    assign chamber_sum_next = chamber_sum_reg - apa_pkg::SUM_W'(oldest.chamber)
                              + apa_pkg::SUM_W'(s_chamber);
    assign outside_sum_next = outside_sum_reg - apa_pkg::SUM_W'(oldest.outside)
                              + apa_pkg::SUM_W'(s_outside);

    assign chamber_avg_calc = apa_pkg::SAMPLE_W'(chamber_sum_next / apa_pkg::WINDOW);
    assign outside_avg_calc = apa_pkg::SAMPLE_W'(outside_sum_next / apa_pkg::WINDOW);
    assign red_calc         = (chamber_avg_calc >= outside_avg_calc);

    // display forces an update, whatever next_update holds
    assign do_update = s_display || (s_now >= next_update_reg);

    // silence acts before the update
    assign armed_sil = armed_reg && !s_silence;
    assign alarm_sil = alarm_active_reg && !s_silence;

    always_comb begin
        armed_next = armed_sil;
        alarm_next = alarm_sil;
        if (do_update) begin
            if (armed_sil) begin
                if (red_calc) begin
                    alarm_next = 1'b1;
                end
            end else if (!red_calc) begin
                armed_next = 1'b1;
            end
        end
    end

    // buzzer phase uses the alarm start held before this item
    assign elapsed = s_now - alarm_start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chamber_sum_reg  <= '0;
            outside_sum_reg  <= '0;
            next_update_reg  <= '0;
            alarm_start_reg  <= '0;
            armed_reg        <= 1'b1;
            alarm_active_reg <= 1'b0;
            red_reg          <= 1'b0;
            chamber_avg_reg  <= '0;
            outside_avg_reg  <= '0;
        end else if (s_fire) begin
            chamber_sum_reg  <= chamber_sum_next;
            outside_sum_reg  <= outside_sum_next;
            armed_reg        <= armed_next;
            alarm_active_reg <= alarm_next;
            if (do_update) begin
                next_update_reg <= s_now + apa_pkg::TIME_W'(interval_reg);
                chamber_avg_reg <= chamber_avg_calc;
                outside_avg_reg <= outside_avg_calc;
                red_reg         <= red_calc;
                if (alarm_next && !alarm_sil) begin
                    alarm_start_reg <= s_now;
                end
            end else if (s_display) begin
                next_update_reg <= s_now;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 payload
    // ------------------------------------------------------------------
    apa_pkg::ind_t              p1_ind_reg;
    apa_pkg::buz_ctl_t          p1_buz_reg;
    logic [apa_pkg::Q_W-1:0]    p1_q_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_ind_reg.updated         <= do_update;
            p1_ind_reg.red             <= do_update ? red_calc : red_reg;
            p1_ind_reg.chamber_average <= do_update ? chamber_avg_calc : chamber_avg_reg;
            p1_ind_reg.outside_average <= do_update ? outside_avg_calc : outside_avg_reg;
            p1_buz_reg.load            <= alarm_sil;
            p1_buz_reg.clear           <= s_silence;
            p1_q_reg                   <= elapsed[apa_pkg::TIME_W-1:apa_pkg::BUZZ_SHIFT];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: phase multiply
    // ------------------------------------------------------------------
    apa_pkg::ind_t     p2_ind_reg;
    apa_pkg::buz_ctl_t p2_buz_reg;
    logic              phase;

    apa_buzz_phase u_phase (
        .aclk    (aclk),
        .load_en (adv1),
        .q       (p1_q_reg),
        .phase   (phase)
    );

    always_ff @(posedge aclk) begin
        if (adv1) begin
            p2_ind_reg <= p1_ind_reg;
            p2_buz_reg <= p1_buz_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: buzzer level kept in item order here
    // ------------------------------------------------------------------
    logic                          buzzer_reg, buzzer_next;
    logic [apa_pkg::M_DATA_W-1:0]  m_data_reg;

    always_comb begin
        buzzer_next = buzzer_reg;
        if (p2_buz_reg.clear) begin
            buzzer_next = 1'b0;
        end
        if (p2_buz_reg.load) begin
            buzzer_next = phase;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buzzer_reg <= 1'b0;
        end else if (adv2) begin
            buzzer_reg <= buzzer_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            m_data_reg <= {2'b00,
                           p2_ind_reg.updated,
                           p2_ind_reg.outside_average,
                           p2_ind_reg.chamber_average,
                           buzzer_next,
                           !p2_ind_reg.red,
                           p2_ind_reg.red};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a latched alarm only exists while armed
    a_alarm_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        alarm_active_reg |-> armed_reg)
        else $error("alarm active while disarmed");

    // silence always leaves the alarm off
    a_silence_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_silence) |=> !alarm_active_reg)
        else $error("alarm survived silence");

    // display forces an update and reschedules from now
    a_display_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_display) |=>
            (next_update_reg == $past(s_now + apa_pkg::TIME_W'(interval_reg))))
        else $error("display did not reschedule update");

    // a stage 1 item is never lost under stall: it stays until it moves on
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !adv1) |=> v1_reg)
        else $error("stage 1 item dropped");

endmodule

[tb/tb.sv]
// ============================================================================
// tb : averaged pressure alarm testbench
// Drives pressure items through the stream port with a bursty sender and a
// stalling receiver, and reprograms the update interval over APB between
// phases. A directed script covers reset, extremes, the buttons and timestamp
// wrap. Random phases follow. Results are checked against an in-bench model
// of the window averages, the alarm and the buzzer, or values typed into the script.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW      = apa_pkg::WINDOW;
    localparam int WINDOW_LOG2 = apa_pkg::WINDOW_LOG2;
    localparam int SAMPLE_W    = apa_pkg::SAMPLE_W;
    localparam int SUM_W       = apa_pkg::SUM_W;
    localparam int TIME_W      = apa_pkg::TIME_W;
    localparam int INTERVAL_W  = apa_pkg::INTERVAL_W;
    localparam int ADDR_W      = apa_pkg::ADDR_W;
    localparam int DATA_W      = apa_pkg::DATA_W;
    localparam int S_DATA_W    = apa_pkg::S_DATA_W;
    localparam int M_DATA_W    = apa_pkg::M_DATA_W;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = apa_pkg::INTERVAL_RESET;

    localparam int                 SAMPLE_MAX      = 131071;
    localparam logic [TIME_W-1:0]  HALF_PERIOD_MS  = 32'd500;
    localparam logic [ADDR_W-1:0]  ADDR_INTERVAL   = 3'd0;
    localparam logic [ADDR_W-1:0]  ADDR_UNMAPPED   = 3'd4;   // no register here
    localparam int                 HOLD_CYCLES     = 300;
    localparam int                 DRAIN_CYCLES    = 6;      // pipe is 3 deep
    localparam int                 NUM_PHASES      = 5;
    localparam int                 ITEMS_PER_PHASE = 320;
    localparam int                 PRINT_CAP       = 200;

    // one input item
    typedef struct packed {
        logic [SAMPLE_W-1:0] chamber;
        logic [SAMPLE_W-1:0] outside;
        logic [TIME_W-1:0]   now;
        logic                silence;
        logic                display;
    } sample_t;

    // one result item
    typedef struct packed {
        logic                red;
        logic                green;
        logic                buzz;
        logic [SAMPLE_W-1:0] ch_avg;
        logic [SAMPLE_W-1:0] out_avg;
        logic                updated;
    } indication_t;

    typedef struct packed {
        sample_t     smp;
        logic        lit;    // expected result typed in below
        indication_t want;
    } script_row_t;

    localparam indication_t NO_IND = '0;

    // ------------------------------------------------------------------------
    // Clock, DUT ports
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // [16:0] chamber, [33:17] outside, [65:34] now_ms, [66] silence,
    // [67] display, [71:68] zero
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // [0] red, [1] green, [2] buzzer, [19:3] chamber avg, [36:20] outside avg,
    // [37] updated, [39:38] zero
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    averaged_pressure_alarm uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Alarm model state (mirrors the block after reset)
    // ------------------------------------------------------------------------
    logic [SAMPLE_W-1:0]   win_chamber [WINDOW];
    logic [SAMPLE_W-1:0]   win_outside [WINDOW];
    logic [WINDOW_LOG2-1:0] slot_ptr;
    logic [SUM_W-1:0]      sum_chamber;
    logic [SUM_W-1:0]      sum_outside;
    logic [TIME_W-1:0]     due_ms;
    logic                  armed;
    logic                  alarm_on;
    logic [TIME_W-1:0]     alarm_t0;
    logic                  buzz_on;
    logic                  red_on;
    logic [SAMPLE_W-1:0]   avg_chamber;
    logic [SAMPLE_W-1:0]   avg_outside;
    logic [INTERVAL_W-1:0] interval_reg;

    indication_t expected_ind[$];
    int          errors;
    int          result_no;
    logic        hold_off_req;

    // random stimulus state
    logic [TIME_W-1:0] clock_ms;
    int                ch_base;
    int                out_base;
    int                rebase_left;
    int                burst_left;

    // Works out one result and moves the model on by one item.
    // Order: display, silence, buzzer phase, window write, then the update.
    function automatic indication_t advance_alarm(input sample_t s);
        indication_t       r;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] half_periods;
        r.updated = 1'b0;
        if (s.display)
            due_ms = s.now;
        if (s.silence) begin
            alarm_on = 1'b0;
            armed    = 1'b0;
            buzz_on  = 1'b0;
        end
        // buzzer phase uses the alarm state from before this item's update
        if (alarm_on) begin
            elapsed      = s.now - alarm_t0;
            half_periods = elapsed / HALF_PERIOD_MS;
            buzz_on      = half_periods[0];
        end
        sum_chamber = sum_chamber - SUM_W'(win_chamber[slot_ptr]) + SUM_W'(s.chamber);
        sum_outside = sum_outside - SUM_W'(win_outside[slot_ptr]) + SUM_W'(s.outside);
        win_chamber[slot_ptr] = s.chamber;
        win_outside[slot_ptr] = s.outside;
        slot_ptr = slot_ptr + 1'b1;
        if (s.now >= due_ms) begin
            due_ms      = s.now + TIME_W'(interval_reg);
            avg_chamber = SAMPLE_W'(sum_chamber / WINDOW);
            avg_outside = SAMPLE_W'(sum_outside / WINDOW);
            red_on      = avg_chamber >= avg_outside;
            if (armed) begin
                if (!alarm_on && red_on) begin
                    alarm_on = 1'b1;
                    alarm_t0 = s.now;
                end
            end else if (!red_on) begin
                armed = 1'b1;   // re-arm once chamber drops below outside
            end
            r.updated = 1'b1;
        end
        r.red     = red_on;
        r.green   = !red_on;
        r.buzz    = buzz_on;
        r.ch_avg  = avg_chamber;
        r.out_avg = avg_outside;
        return r;
    endfunction

    function automatic int clamp_sample(input int v);
        if (v < 0)
            return 0;
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        return v;
    endfunction

    function automatic script_row_t row(input logic [TIME_W-1:0] now,
                                        input int cp, input int op,
                                        input logic sil, input logic disp,
                                        input logic lit, input indication_t want);
        script_row_t r;
        r.smp.chamber = SAMPLE_W'(cp);
        r.smp.outside = SAMPLE_W'(op);
        r.smp.now     = now;
        r.smp.silence = sil;
        r.smp.display = disp;
        r.lit         = lit;
        r.want        = want;
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // APB: setup phase, then access phase until pready, then return to idle
    // ------------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        logic ok;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            ok    = pready;
            rdata = prdata;
            @(posedge aclk);
        end while (!ok);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_interval();
        logic [DATA_W-1:0] rd;
        apb_access(1'b0, ADDR_INTERVAL, '0, rd);
        if (rd !== DATA_W'(interval_reg))
            note_mismatch($sformatf("interval readback got %0d want %0d", rd, interval_reg));
    endtask

    // Sender stops and waits for every outstanding result, then for the pipe.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_ind.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_interval(input logic [INTERVAL_W-1:0] v);
        logic [DATA_W-1:0] rd;
        drain();
        // upper bits are junk: the register keeps only 16
        apb_access(1'b1, ADDR_INTERVAL, {16'($urandom), v}, rd);
        interval_reg = v;
        check_interval();
    endtask

    // ------------------------------------------------------------------------
    // Stream sender: offer one item, hold it until accepted
    // ------------------------------------------------------------------------
    task automatic offer(input sample_t s, input logic lit, input indication_t want);
        indication_t predicted;
        logic        ok;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, s.display, s.silence, s.now, s.outside, s.chamber};
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        predicted = advance_alarm(s);
        expected_ind.push_back(lit ? want : predicted);
    endtask

    // Burst pacing: either carry on or drop valid for a random gap.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Mostly a steadily advancing clock with pressures hovering around two
    // bases that cross now and then; some items are pure noise.
    task automatic next_random(output sample_t s);
        int step_max;
        if (rebase_left == 0) begin
            rebase_left = $urandom_range(10, 60);
            ch_base     = $urandom_range(0, SAMPLE_MAX);
            out_base    = clamp_sample(ch_base + int'($urandom_range(0, 6000)) - 3000);
        end
        rebase_left--;
        if ($urandom_range(0, 11) == 0) begin
            s.chamber = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            s.outside = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            s.now     = $urandom();
            s.silence = 1'($urandom_range(0, 1));
            s.display = 1'($urandom_range(0, 1));
        end else begin
            step_max  = int'(interval_reg) / 3 + 20;
            clock_ms  = clock_ms + TIME_W'($urandom_range(0, step_max));
            s.chamber = SAMPLE_W'(clamp_sample(ch_base + int'($urandom_range(0, 1000)) - 500));
            s.outside = SAMPLE_W'(clamp_sample(out_base + int'($urandom_range(0, 1000)) - 500));
            s.now     = clock_ms;
            s.silence = ($urandom_range(0, 24) == 0);
            s.display = ($urandom_range(0, 14) == 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall pattern in segments; one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int seg;
        int pct;
        m_tready = 1'b0;
        forever begin
            seg = $urandom_range(4, 60);
            case ($urandom_range(0, 3))
                0: pct = 100;
                1: pct = 80;
                2: pct = 45;
                default: pct = 15;
            endcase
            repeat (seg) begin
                @(posedge aclk);
                if (hold_off_req) begin
                    // long stall so the pipe fills and s_tready drops
                    m_tready <= 1'b0;
                    hold_off_req = 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end else begin
                    m_tready <= ($urandom_range(0, 99) < pct);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: sampled mid-cycle, away from the driving edge
    // ------------------------------------------------------------------------
    indication_t got_ind;
    indication_t want_ind;

    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_ind.red     = m_tdata[0];
            got_ind.green   = m_tdata[1];
            got_ind.buzz    = m_tdata[2];
            got_ind.ch_avg  = m_tdata[19:3];
            got_ind.out_avg = m_tdata[36:20];
            got_ind.updated = m_tdata[37];
            if (expected_ind.size() == 0) begin
                note_mismatch($sformatf("result %0d with nothing expected", result_no));
            end else begin
                want_ind = expected_ind.pop_front();
                if (got_ind.red !== want_ind.red)
                    note_mismatch($sformatf("result %0d red_led got %b want %b",
                                            result_no, got_ind.red, want_ind.red));
                if (got_ind.green !== want_ind.green)
                    note_mismatch($sformatf("result %0d green_led got %b want %b",
                                            result_no, got_ind.green, want_ind.green));
                if (got_ind.buzz !== want_ind.buzz)
                    note_mismatch($sformatf("result %0d buzzer got %b want %b",
                                            result_no, got_ind.buzz, want_ind.buzz));
                if (got_ind.ch_avg !== want_ind.ch_avg)
                    note_mismatch($sformatf("result %0d chamber_average got %0d want %0d",
                                            result_no, got_ind.ch_avg, want_ind.ch_avg));
                if (got_ind.out_avg !== want_ind.out_avg)
                    note_mismatch($sformatf("result %0d outside_average got %0d want %0d",
                                            result_no, got_ind.out_avg, want_ind.out_avg));
                if (got_ind.updated !== want_ind.updated)
                    note_mismatch($sformatf("result %0d updated got %b want %b",
                                            result_no, got_ind.updated, want_ind.updated));
                if (m_tdata[39:38] !== 2'b00)
                    note_mismatch($sformatf("result %0d padding not zero", result_no));
            end
            result_no++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        script_row_t       script[$];
        sample_t           smp;
        logic [DATA_W-1:0] rd;
        int                ph;
        int                n;

        // all block inputs known from time zero
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        // model at reset
        foreach (win_chamber[i]) begin
            win_chamber[i] = '0;
            win_outside[i] = '0;
        end
        slot_ptr     = '0;
        sum_chamber  = '0;
        sum_outside  = '0;
        due_ms       = '0;     // first item always updates
        armed        = 1'b1;
        alarm_on     = 1'b0;
        alarm_t0     = '0;
        buzz_on      = 1'b0;
        red_on       = 1'b0;
        avg_chamber  = '0;
        avg_outside  = '0;
        interval_reg = INTERVAL_RESET;
        errors       = 0;
        result_no    = 0;
        hold_off_req = 1'b0;
        rebase_left  = 0;
        burst_left   = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_interval();

        // Directed script. Order: red, green, buzz, ch_avg, out_avg, updated.
        // First item after reset: empty windows, 0 >= 0 so red and the alarm latches.
        script.push_back(row(32'd0, 0, 0, 1'b0, 1'b0, 1'b1,
                             '{1'b1, 1'b0, 1'b0, 17'd0, 17'd0, 1'b1}));
        // before the next update time; buzzer still in its first half period
        script.push_back(row(32'd499, SAMPLE_MAX, 0, 1'b0, 1'b0, 1'b1,
                             '{1'b1, 1'b0, 1'b0, 17'd0, 17'd0, 1'b0}));
        // 500 ms into the alarm: buzzer flips, averages held
        script.push_back(row(32'd500, SAMPLE_MAX, 0, 1'b0, 1'b0, 1'b1,
                             '{1'b1, 1'b0, 1'b1, 17'd0, 17'd0, 1'b0}));
        script.push_back(row(32'd1000, SAMPLE_MAX, 0, 1'b0, 1'b0, 1'b0, NO_IND));
        // silence: alarm cleared and disarmed
        script.push_back(row(32'd1200, 0, SAMPLE_MAX, 1'b1, 1'b0, 1'b0, NO_IND));
        // forced update while disarmed and still red
        script.push_back(row(32'd1300, 0, SAMPLE_MAX, 1'b0, 1'b1, 1'b0, NO_IND));
        script.push_back(row(32'd1400, 0, SAMPLE_MAX, 1'b0, 1'b0, 1'b0, NO_IND));
        script.push_back(row(32'd1500, 0, SAMPLE_MAX, 1'b0, 1'b0, 1'b0, NO_IND));
        script.push_back(row(32'd1600, 0, SAMPLE_MAX, 1'b0, 1'b0, 1'b0, NO_IND));
        script.push_back(row(32'd1700, 0, SAMPLE_MAX, 1'b0, 1'b0, 1'b0, NO_IND));
        // outside now ahead: green, re-arms
        script.push_back(row(32'd1800, 0, SAMPLE_MAX, 1'b0, 1'b1, 1'b0, NO_IND));
        script.push_back(row(32'd2500, SAMPLE_MAX, 0, 1'b0, 1'b1, 1'b0, NO_IND));
        script.push_back(row(32'd3000, SAMPLE_MAX, 0, 1'b0, 1'b0, 1'b0, NO_IND));
        // both buttons on one item
        script.push_back(row(32'd3100, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b1, 1'b0, NO_IND));
        // next update time wraps to zero: every item updates until now wraps
        script.push_back(row(32'hFFFF_FC18, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b1, 1'b0, NO_IND));
        script.push_back(row(32'hFFFF_FE00, 'h15555, 'h0AAAA, 1'b0, 1'b0, 1'b0, NO_IND));
        script.push_back(row(32'hFFFF_FFFF, 'h0AAAA, 'h15555, 1'b0, 1'b0, 1'b0, NO_IND));
        script.push_back(row(32'd0, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0, 1'b0, NO_IND));
        // timestamp jumps forwards and backwards
        script.push_back(row(32'h8000_0000, 0, 0, 1'b0, 1'b1, 1'b0, NO_IND));
        script.push_back(row(32'h0000_1000, 1, 1, 1'b0, 1'b0, 1'b0, NO_IND));
        script.push_back(row(32'h5555_5555, 'h10000, 'h10000, 1'b0, 1'b0, 1'b0, NO_IND));
        script.push_back(row(32'hAAAA_AAAA, SAMPLE_MAX, 0, 1'b0, 1'b1, 1'b0, NO_IND));

        foreach (script[i]) begin
            offer(script[i].smp, script[i].lit, script[i].want);
            pace();
        end
        clock_ms = 32'hAAAA_AAAA;

        // Random phases, each at its own interval
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: hold_off_req = 1'b1;
                1: set_interval(16'd0);
                2: begin
                    set_interval(16'd1);
                    // write to an unmapped address must leave the interval alone
                    apb_access(1'b1, ADDR_UNMAPPED, $urandom(), rd);
                    check_interval();
                end
                3: begin
                    set_interval(16'hFFFF);
                    clock_ms = 32'hFFFF_FFFF - 32'd400000;   // wraps within the phase
                end
                default: set_interval(INTERVAL_W'($urandom_range(2, 400)));
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                next_random(smp);
                offer(smp, 1'b0, NO_IND);
                pace();
                if (ph == NUM_PHASES - 1 && n == ITEMS_PER_PHASE / 2)
                    drain();   // sender pauses until everything is back
            end
        end

        drain();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run limit, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[averaged_pressure_alarm.f]
design/apa_pkg.sv
design/apa_cell.sv
design/apa_buzz_phase.sv
design/averaged_pressure_alarm.sv
tb/tb.sv
